>>> rtl/core/cbq_pkg.sv
// Shared types and constants of the cascaded biquad filter core.
package cbq_pkg;

	localparam int SAMPLE_W          = 24;
	localparam int COEF_W            = 24;
	localparam int PROD_W            = SAMPLE_W + COEF_W;
	localparam int ACC_W             = PROD_W + 3;
	localparam int FRAC_SHIFT        = 22;
	localparam int RND_W             = ACC_W - FRAC_SHIFT;
	localparam int COEFS_PER_SECTION = 6;
	localparam int STEP_W            = 4;
	localparam int S24_MAX           = 8388607;
	localparam int S24_MIN           = -8388608;

	typedef enum logic [1:0] {
		CMD_FILTER = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		SLOT_B0 = 3'd0,
		SLOT_B1 = 3'd1,
		SLOT_B2 = 3'd2,
		SLOT_A0 = 3'd3,
		SLOT_A1 = 3'd4,
		SLOT_A2 = 3'd5
	} slot_t;

	typedef enum logic [2:0] {
		OPND_X  = 3'd0,
		OPND_X1 = 3'd1,
		OPND_X2 = 3'd2,
		OPND_Y1 = 3'd3,
		OPND_Y2 = 3'd4
	} opnd_t;

	typedef enum logic [1:0] {
		ACC_NONE = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2,
		ACC_SUB  = 2'd3
	} acc_op_t;

	typedef enum logic [1:0] {
		SEQ_NEXT = 2'd0,
		SEQ_LOOP = 2'd1,
		SEQ_EMIT = 2'd2
	} seq_op_t;

	typedef struct packed {
		logic              coef_rd;
		slot_t             coef_slot;
		logic              hist_rd;
		logic              mul_en;
		opnd_t             opnd;
		acc_op_t           acc_op;
		logic              wb;
		seq_op_t           seq_op;
		logic [STEP_W-1:0] target;
	} ctl_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x1;
		logic signed [SAMPLE_W-1:0] x2;
		logic signed [SAMPLE_W-1:0] y1;
		logic signed [SAMPLE_W-1:0] y2;
	} hist_t;

endpackage

>>> rtl/core/cbq_seq.sv
// Microcode sequencer: step counter, control store and loop/emit jumps.
module cbq_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                last_sec,
	input  logic                out_room,
	output cbq_pkg::ctl_word_t  ctl,
	output logic                emit,
	output logic                busy
);
	import cbq_pkg::*;

	localparam logic [STEP_W-1:0] LOOP_TOP = STEP_W'(0);

	function automatic ctl_word_t ucode_rom(input logic [STEP_W-1:0] addr);
		ctl_word_t w;
		w = '0;
		unique case (addr)
			4'd0: begin
				w.coef_rd = 1'b1; w.coef_slot = SLOT_B0; w.hist_rd = 1'b1;
			end
			4'd1: begin
				w.coef_rd = 1'b1; w.coef_slot = SLOT_B1;
				w.mul_en = 1'b1; w.opnd = OPND_X;
			end
			4'd2: begin
				w.coef_rd = 1'b1; w.coef_slot = SLOT_B2;
				w.mul_en = 1'b1; w.opnd = OPND_X1; w.acc_op = ACC_LOAD;
			end
			4'd3: begin
				w.coef_rd = 1'b1; w.coef_slot = SLOT_A1;
				w.mul_en = 1'b1; w.opnd = OPND_X2; w.acc_op = ACC_ADD;
			end
			4'd4: begin
				w.coef_rd = 1'b1; w.coef_slot = SLOT_A2;
				w.mul_en = 1'b1; w.opnd = OPND_Y1; w.acc_op = ACC_ADD;
			end
			4'd5: begin
				w.mul_en = 1'b1; w.opnd = OPND_Y2; w.acc_op = ACC_SUB;
			end
			4'd6: begin
				w.acc_op = ACC_SUB;
			end
			4'd7: begin
				w.wb = 1'b1; w.seq_op = SEQ_LOOP; w.target = LOOP_TOP;
			end
			4'd8: begin
				w.seq_op = SEQ_EMIT;
			end
			default: begin
				w = '0;
			end
		endcase
		return w;
	endfunction

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	ctl_word_t         word;

	assign word = ucode_rom(step_q);
	assign ctl  = busy_q ? word : '0;
	assign busy = busy_q;
	assign emit = busy_q && (word.seq_op == SEQ_EMIT) && out_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			step_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			unique case (word.seq_op)
				SEQ_NEXT: step_q <= step_q + STEP_W'(1);
				SEQ_LOOP: step_q <= last_sec ? step_q + STEP_W'(1) : word.target;
				SEQ_EMIT: begin
					// hold here until the output register has room
					if (out_room) begin
						busy_q <= 1'b0;
					end
				end
				default: step_q <= '0;
			endcase
		end
	end

endmodule

>>> rtl/core/cbq_dp.sv
// Datapath: coefficient and history memories, shared multiplier, accumulator, rounding.
module cbq_dp #(
	parameter int MAX_SECTIONS = 8,
	parameter int CA_W         = 6,
	parameter int SEC_W        = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cbq_pkg::ctl_word_t                   ctl,
	input  logic                                 start,
	input  logic signed [cbq_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                 coef_we,
	input  logic [CA_W-1:0]                      coef_waddr,
	input  logic signed [cbq_pkg::COEF_W-1:0]    coef_wdata,
	input  logic                                 hist_clear,
	input  logic [SEC_W-1:0]                     last_idx,
	output logic                                 last_sec,
	output logic signed [cbq_pkg::SAMPLE_W-1:0]  y,
	output logic                                 sat
);
	import cbq_pkg::*;

	localparam int COEF_DEPTH = MAX_SECTIONS * COEFS_PER_SECTION;
	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (FRAC_SHIFT - 1);
	localparam logic signed [RND_W-1:0] RND_MAX  = RND_W'(S24_MAX);
	localparam logic signed [RND_W-1:0] RND_MIN  = RND_W'(S24_MIN);

	logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];
	logic [COEF_DEPTH-1:0]      coef_vld;
	logic signed [COEF_W-1:0]   coef_rd_q;
	logic                       coef_vld_q;
	hist_t                      hist_mem [MAX_SECTIONS];
	logic [MAX_SECTIONS-1:0]    hist_vld;
	hist_t                      hist_rd_q;
	logic                       hist_vld_q;

	logic [SEC_W-1:0]           sec_q;
	logic [CA_W-1:0]            base_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic                       sat_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0]    acc_q;

	logic [CA_W-1:0]            coef_raddr;
	logic signed [COEF_W-1:0]   coef_eff;
	hist_t                      hist_eff;
	logic signed [SAMPLE_W-1:0] opnd_v;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    rsum;
	logic signed [RND_W-1:0]    rnd;
	logic signed [SAMPLE_W-1:0] y_sat;
	logic                       clip;
	hist_t                      hist_new;

	assign coef_raddr = base_q + CA_W'(ctl.coef_slot);
	assign coef_eff   = coef_vld_q ? coef_rd_q : '0;
	assign hist_eff   = hist_vld_q ? hist_rd_q : '0;
	assign prod_ext   = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign last_sec   = (sec_q == last_idx);
	assign y          = x_q;
	assign sat        = sat_q;

	always_comb begin
		unique case (ctl.opnd)
			OPND_X:  opnd_v = x_q;
			OPND_X1: opnd_v = hist_eff.x1;
			OPND_X2: opnd_v = hist_eff.x2;
			OPND_Y1: opnd_v = hist_eff.y1;
			OPND_Y2: opnd_v = hist_eff.y2;
			default: opnd_v = '0;
		endcase
	end

	// round half up to Q1.23, then clip to 24 bits
	always_comb begin
		rsum = acc_q + RND_BIAS;
		rnd  = $signed(rsum[ACC_W-1:FRAC_SHIFT]);
		clip = 1'b0;
		if (rnd > RND_MAX) begin
			y_sat = SAMPLE_W'(S24_MAX);
			clip  = 1'b1;
		end else if (rnd < RND_MIN) begin
			y_sat = SAMPLE_W'(S24_MIN);
			clip  = 1'b1;
		end else begin
			y_sat = rnd[SAMPLE_W-1:0];
		end
		hist_new.x1 = x_q;
		hist_new.x2 = hist_eff.x1;
		hist_new.y1 = y_sat;
		hist_new.y2 = hist_eff.y1;
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= coef_wdata;
		end
		if (ctl.coef_rd) begin
			coef_rd_q <= coef_mem[coef_raddr];
		end
		if (ctl.wb) begin
			hist_mem[sec_q] <= hist_new;
		end
		if (ctl.hist_rd) begin
			hist_rd_q <= hist_mem[sec_q];
		end
		if (ctl.mul_en) begin
			prod_s1 <= coef_eff * opnd_v;
		end
		case (ctl.acc_op)
			ACC_LOAD: acc_q <= prod_ext;
			ACC_ADD:  acc_q <= acc_q + prod_ext;
			ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:  acc_q <= acc_q;
		endcase
		if (start) begin
			x_q <= sample_in;
		end else if (ctl.wb) begin
			x_q <= y_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld   <= '0;
			coef_vld_q <= 1'b0;
			hist_vld   <= '0;
			hist_vld_q <= 1'b0;
			sec_q      <= '0;
			base_q     <= '0;
			sat_q      <= 1'b0;
		end else begin
			if (coef_we) begin
				coef_vld[coef_waddr] <= 1'b1;
			end
			if (ctl.coef_rd) begin
				coef_vld_q <= coef_vld[coef_raddr];
			end
			if (ctl.hist_rd) begin
				hist_vld_q <= hist_vld[sec_q];
			end
			if (hist_clear) begin
				hist_vld <= '0;
			end else if (ctl.wb) begin
				hist_vld[sec_q] <= 1'b1;
			end
			if (start) begin
				sec_q  <= '0;
				base_q <= '0;
				sat_q  <= 1'b0;
			end else if (ctl.wb) begin
				sec_q  <= sec_q + SEC_W'(1);
				base_q <= base_q + CA_W'(COEFS_PER_SECTION);
				sat_q  <= sat_q | clip;
			end
		end
	end

endmodule

>>> rtl/core/cascaded_biquad_iir_filter_core.sv
// Top level of the cascaded biquad filter: handshakes, command decode, config, output register.
//
// Cascade of up to MAX_SECTIONS direct form I biquads on Q1.23 samples with Q2.22
// coefficients. A filter item runs through the active sections one after another on a
// single 24x24 multiplier and one coefficient read port, five products in eight steps per
// section plus one step to hand the result to the output register. in_stall is high
// while a filter item runs and while its result waits for room behind an earlier result
// in a stalled output register. Load and clear items are taken whenever in_stall is low
// and give no result. Coefficients and histories read as zero after reset; a clear item
// zeroes all histories at once and keeps the coefficients. The result waits in an output
// register, so load and clear items are still taken while it is stalled. Write
// section_count (cfg_wdata) only while the block is idle.
module cascaded_biquad_iir_filter_core #(
	parameter int MAX_SECTIONS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [3:0]                          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          command,
	input  logic signed [cbq_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [2:0]                          coef_section,
	input  logic [2:0]                          coef_slot,
	input  logic signed [cbq_pkg::COEF_W-1:0]   coef_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [cbq_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                saturated
);
	import cbq_pkg::*;

	localparam int COEF_DEPTH = MAX_SECTIONS * COEFS_PER_SECTION;
	localparam int CA_W       = $clog2(COEF_DEPTH);
	localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

	logic [3:0]                 section_count_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       saturated_q;

	logic                       accept;
	logic                       start;
	logic                       coef_we;
	logic                       hist_clear;
	logic [8:0]                 load_addr;
	logic [5:0]                 nsec;
	logic [SEC_W-1:0]           last_idx;
	logic                       last_sec;
	logic                       out_room;
	logic                       emit;
	logic                       busy;
	ctl_word_t                  ctl;
	logic signed [SAMPLE_W-1:0] y;
	logic                       sat;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = busy;
	assign start      = accept && (command == CMD_FILTER);
	assign hist_clear = accept && (command == CMD_CLEAR);
	// drop loads aimed past the coefficient store
	assign coef_we    = accept && (command == CMD_LOAD)
	                    && (6'(coef_section) < 6'(MAX_SECTIONS))
	                    && (coef_slot < 3'(COEFS_PER_SECTION));
	assign load_addr  = 9'(coef_section) * 9'(COEFS_PER_SECTION) + 9'(coef_slot);

	always_comb begin
		if (section_count_q == 4'd0) begin
			nsec = 6'd1;
		end else if (6'(section_count_q) > 6'(MAX_SECTIONS)) begin
			nsec = 6'(MAX_SECTIONS);
		end else begin
			nsec = 6'(section_count_q);
		end
		last_idx = SEC_W'(nsec - 6'd1);
	end

	assign out_room   = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign saturated  = saturated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_count_q <= 4'd1;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				section_count_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sample_out_q <= y;
			saturated_q  <= sat;
		end
	end

	cbq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_sec (last_sec),
		.out_room (out_room),
		.ctl      (ctl),
		.emit     (emit),
		.busy     (busy)
	);

	cbq_dp #(
		.MAX_SECTIONS (MAX_SECTIONS),
		.CA_W         (CA_W),
		.SEC_W        (SEC_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.start      (start),
		.sample_in  (sample_in),
		.coef_we    (coef_we),
		.coef_waddr (CA_W'(load_addr)),
		.coef_wdata (coef_value),
		.hist_clear (hist_clear),
		.last_idx   (last_idx),
		.last_sec   (last_sec),
		.y          (y),
		.sat        (sat)
	);

endmodule

>>> sim/tb.sv
// Self-checking testbench for the cascaded biquad filter core: loads, clears and streams samples.
`timescale 1ns / 100ps

module tb;
	import cbq_pkg::*;

	localparam int          MAX_SECTIONS = 8;
	localparam int          LIMIT_CYCLES = 1000000;
	localparam int          DRAIN_CYCLES = 80;
	localparam int          LONG_HOLD    = 400;
	localparam int          PHASE_ITEMS  = 133;
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;
	localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
	localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;
	localparam logic signed [COEF_W-1:0] ONE_Q22  = 24'sh400000;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       sat;
	} filt_result_t;

	class biquad_scoreboard;
		logic signed [COEF_W-1:0]   coef [MAX_SECTIONS][COEFS_PER_SECTION];
		logic signed [SAMPLE_W-1:0] x1 [MAX_SECTIONS];
		logic signed [SAMPLE_W-1:0] x2 [MAX_SECTIONS];
		logic signed [SAMPLE_W-1:0] y1 [MAX_SECTIONS];
		logic signed [SAMPLE_W-1:0] y2 [MAX_SECTIONS];
		logic [3:0]                 section_count;
		filt_result_t               pending_out [$];
		int                         errors;
		int                         results;
		int                         clipped;

		function new();
			foreach (coef[s, k])
				coef[s][k] = '0;
			clear_history();
			section_count = 4'd1;
			errors        = 0;
			results       = 0;
			clipped       = 0;
		endfunction

		function void clear_history();
			foreach (x1[s]) begin
				x1[s] = '0;
				x2[s] = '0;
				y1[s] = '0;
				y2[s] = '0;
			end
		endfunction

		function int active_sections();
			if (section_count == 0)
				return 1;
			if (section_count > MAX_SECTIONS)
				return MAX_SECTIONS;
			return section_count;
		endfunction

		function void note_item(logic [1:0] cmd, logic signed [SAMPLE_W-1:0] smp,
				logic [2:0] sec, logic [2:0] slot, logic signed [COEF_W-1:0] val);
			int                         n;
			longint                     acc;
			longint                     rnd;
			logic signed [SAMPLE_W-1:0] x;
			logic signed [SAMPLE_W-1:0] y;
			logic                       clip;
			filt_result_t               r;
			case (cmd)
			CMD_LOAD: begin
				if (slot <= SLOT_A2)
					coef[sec][slot] = val;
			end
			CMD_CLEAR: clear_history();
			CMD_FILTER: begin
				n    = active_sections();
				x    = smp;
				clip = 1'b0;
				for (int s = 0; s < n; s++) begin
					acc = longint'(coef[s][SLOT_B0]) * longint'(x)
						+ longint'(coef[s][SLOT_B1]) * longint'(x1[s])
						+ longint'(coef[s][SLOT_B2]) * longint'(x2[s])
						- longint'(coef[s][SLOT_A1]) * longint'(y1[s])
						- longint'(coef[s][SLOT_A2]) * longint'(y2[s]);
					// round half up from Q3.45 to Q1.23
					rnd = (acc + (longint'(1) << 21)) >>> FRAC_SHIFT;
					if (rnd > S24_MAX) begin
						y    = SAMPLE_W'(S24_MAX);
						clip = 1'b1;
					end else if (rnd < S24_MIN) begin
						y    = SAMPLE_W'(S24_MIN);
						clip = 1'b1;
					end else begin
						y = rnd[SAMPLE_W-1:0];
					end
					x2[s] = x1[s];
					x1[s] = x;
					y2[s] = y1[s];
					y1[s] = y;
					x     = y;
				end
				r.sample = x;
				r.sat    = clip;
				pending_out.push_back(r);
			end
			default: ;
			endcase
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic signed [SAMPLE_W-1:0] got_sample, logic got_sat);
			filt_result_t want;
			if (pending_out.size() == 0) begin
				report($sformatf("result %0d arrived with nothing pending", got_sample));
			end else begin
				want = pending_out.pop_front();
				results++;
				if (got_sat)
					clipped++;
				if (got_sample !== want.sample)
					report($sformatf("sample_out %0d, predicted %0d (result %0d)",
						got_sample, want.sample, results));
				if (got_sat !== want.sat)
					report($sformatf("saturated %0b, predicted %0b (result %0d)",
						got_sat, want.sat, results));
			end
		endtask
	endclass

	logic                        clk;
	logic                        arst_n       = 1'b0;
	logic                        cfg_we       = 1'b0;
	logic [3:0]                  cfg_wdata    = '0;
	logic                        in_valid     = 1'b0;
	logic                        in_stall;
	logic [1:0]                  command      = CMD_FILTER;
	logic signed [SAMPLE_W-1:0]  sample_in    = '0;
	logic [2:0]                  coef_section = '0;
	logic [2:0]                  coef_slot    = '0;
	logic signed [COEF_W-1:0]    coef_value   = '0;
	logic                        out_valid;
	logic                        out_stall    = 1'b0;
	logic signed [SAMPLE_W-1:0]  sample_out;
	logic                        saturated;

	biquad_scoreboard sb;
	int  counted       = 0;
	int  sent          = 0;
	int  cycles        = 0;
	bit  quiet         = 1'b0;
	int  hold_requests = 0;
	int  hold_served   = 0;
	int  hold_left     = 0;
	int  stall_left    = 0;
	int  phase_counts [10] = '{8, 0, 15, 3, 9, 1, 5, 2, 7, 8};

	cascaded_biquad_iir_filter_core #(
		.MAX_SECTIONS(MAX_SECTIONS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.sample_in   (sample_in),
		.coef_section(coef_section),
		.coef_slot   (coef_slot),
		.coef_value  (coef_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_out  (sample_out),
		.saturated   (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles", LIMIT_CYCLES);
		$display("TB_ERROR");
		$finish;
	end

	// Result side: check each result taken from the output, then pick the next stall value.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall)
			sb.check_result(sample_out, saturated);
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left   <= LONG_HOLD;
			out_stall   <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int v;
		v = $urandom();
		case ($urandom_range(0, 9))
		0:       return SAMPLE_W'(S24_MAX);
		1:       return SAMPLE_W'(S24_MIN);
		2, 3:    return SAMPLE_W'($signed($urandom_range(0, 4095)) - 2048);
		default: return v[SAMPLE_W-1:0];
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef(bit feedback);
		int v;
		v = $urandom();
		case ($urandom_range(0, 9))
		0: return COEF_MAX;
		1: return COEF_MIN;
		2, 3, 4, 5, 6: begin
			// keep feedback taps small so the cascade stays mostly in range
			if (feedback)
				v = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
			else
				v = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
			return v[COEF_W-1:0];
		end
		default: return v[COEF_W-1:0];
		endcase
	endfunction

	task automatic send_item(logic [1:0] cmd, logic signed [SAMPLE_W-1:0] smp,
			logic [2:0] sec, logic [2:0] slot, logic signed [COEF_W-1:0] val);
		command      <= cmd;
		sample_in    <= smp;
		coef_section <= sec;
		coef_slot    <= slot;
		coef_value   <= val;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(cmd, smp, sec, slot, val);
		sent++;
		if (!(cmd == CMD_UNUSED || (cmd == CMD_LOAD && slot > SLOT_A2)))
			counted++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic filter(logic signed [SAMPLE_W-1:0] smp);
		int junk;
		junk = $urandom();
		send_item(CMD_FILTER, smp, junk[2:0], junk[5:3], junk[31:8]);
	endtask

	task automatic load(logic [2:0] sec, logic [2:0] slot, logic signed [COEF_W-1:0] val);
		send_item(CMD_LOAD, rand_sample(), sec, slot, val);
	endtask

	task automatic clear_all();
		int junk;
		junk = $urandom();
		send_item(CMD_CLEAR, rand_sample(), junk[2:0], junk[5:3], junk[31:8]);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_out.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_sections(logic [3:0] v);
		wait_drain();
		// loads and clears give no result, so let any last one finish
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we           <= 1'b0;
		sb.section_count = v;
	endtask

	task automatic load_set();
		int n;
		n = ($urandom_range(0, 3) == 0) ? MAX_SECTIONS : sb.active_sections();
		for (int s = 0; s < n; s++)
			for (int k = 0; k < COEFS_PER_SECTION; k++)
				load(s[2:0], k[2:0], rand_coef(k >= SLOT_A1));
	endtask

	task automatic run_phase(int target, bit do_hold, bit do_pause);
		int start;
		int r;
		int junk;
		bit held;
		bit paused;
		start  = counted;
		held   = 1'b0;
		paused = 1'b0;
		while (counted - start < target) begin
			if (do_hold && !held && counted - start >= 40) begin
				held          = 1'b1;
				hold_requests <= hold_requests + 1;
			end
			if (do_pause && !paused && counted - start >= 70) begin
				paused = 1'b1;
				wait_drain();
			end
			r    = $urandom_range(0, 99);
			junk = $urandom();
			if (r < 5) begin
				load_set();
				if ($urandom_range(0, 1))
					clear_all();
			end else if (r < 10) begin
				case ($urandom_range(0, 3))
				0: load(junk[2:0], junk[5:3], rand_coef(junk[6]));
				1: send_item(CMD_UNUSED, rand_sample(), junk[2:0], junk[5:3], junk[31:8]);
				2: clear_all();
				default: load(junk[2:0], 3'($urandom_range(COEFS_PER_SECTION, 7)),
					junk[31:8]);
				endcase
			end else begin
				repeat ($urandom_range(1, 20))
					filter(rand_sample());
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every command, ignored words and slots
		filter(0);
		load(0, SLOT_B0, ONE_Q22);
		load(0, SLOT_A0, COEF_MIN);
		filter(SAMPLE_W'(S24_MAX));
		filter(SAMPLE_W'(S24_MIN));
		load(0, SLOT_B0, COEF_MAX);
		filter(SAMPLE_W'(S24_MAX));
		filter(SAMPLE_W'(S24_MIN));
		load(0, SLOT_B1, COEF_MIN);
		load(0, SLOT_B2, COEF_MAX);
		load(0, SLOT_A1, COEF_MIN);
		load(0, SLOT_A2, COEF_MAX);
		filter(1);
		filter(-1);
		filter(SAMPLE_W'(S24_MAX));
		for (int k = COEFS_PER_SECTION; k < 8; k++)
			load(0, k[2:0], ONE_Q22);
		send_item(CMD_UNUSED, SAMPLE_W'(S24_MAX), 3'd7, 3'd7, COEF_MAX);
		clear_all();
		filter(SAMPLE_W'(S24_MAX));
		load(7, SLOT_B0, ONE_Q22);
		filter(12345);
		clear_all();
		filter(0);

		foreach (phase_counts[i]) begin
			set_sections(4'(phase_counts[i]));
			if (i == $size(phase_counts) - 1)
				quiet <= 1'b1;
			run_phase(PHASE_ITEMS, i == 3, i == 5);
		end

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_out.size() != 0)
			sb.report($sformatf("%0d predicted results never arrived", sb.pending_out.size()));
		$display("Sent %0d items (%0d effective) over %0d section-count settings in %0d cycles.",
			sent, counted, $size(phase_counts) + 1, cycles);
		$display("Checked %0d filtered results, %0d saturated, %0d mismatches.",
			sb.results, sb.clipped, sb.errors);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
